// ----- src/first_fit_heap_allocator_core_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros for the first fit heap allocator
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FFHA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffha assertion failed");

// antecedent implies consequent in the next cycle
`define FFHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffha assertion failed");

`endif

// ----- src/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int MAX_CHUNKS   = 64;
    localparam int IDX_W        = $clog2(MAX_CHUNKS);
    localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 8;
    localparam logic [16:0] HEAP_CAP = 17'h10000;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_CALLOC  = 2'd1;
    localparam logic [1:0] CMD_FREE    = 2'd2;
    localparam logic [1:0] CMD_REALLOC = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOMEM   = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_FREED   = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] req_size;
        logic [31:0] elem_count;
        logic [15:0] data_addr;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_addr;
        logic        reused;
        logic [15:0] copy_from;
        logic [16:0] copy_bytes;
        logic        zero_fill;
    } t_rsp;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] cap;
        logic [16:0] used;
        logic        free;
    } t_chunk;

endpackage

// ----- src/ffha_cell.sv -----
// ----------------------------------------------------------------------------
// ffha_cell
// one table entry of the rotating chunk chain
// ----------------------------------------------------------------------------
module ffha_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  ffha_pkg::t_chunk i_chunk,
    output ffha_pkg::t_chunk o_chunk
);
    import ffha_pkg::*;

    t_chunk r_chunk;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_chunk <= i_chunk;
        end
    end

    assign o_chunk = r_chunk;

endmodule

// ----- src/first_fit_heap_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// first fit chunk table allocator serving alloc, calloc, free and realloc
// ----------------------------------------------------------------------------
// Each command passes through these steps from accept to a valid result: the
// calloc multiply, size rounding, a scan pass, a decision step, an update pass
// around the ring of chunk cells (one entry reaches the head per cycle) and
// loading of the result register. A new command is accepted in the cycle after
// that, so the block takes no new command until the last result is registered;
// a stalled result holds the block in its last state until the result register
// is free.
module first_fit_heap_allocator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ffha_pkg::t_req i_in_beat,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ffha_pkg::t_rsp o_out_beat,
    input  logic          i_cfg_we,
    input  logic [16:0]   i_cfg_wdata
);
    import ffha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_PREP, S_SCAN, S_DECIDE, S_UPD, S_DONE
    } t_state;

    t_state           r_state;
    t_req             r_req;
    logic [63:0]      r_prod;
    logic [17:0]      r_sz;
    logic [17:0]      r_rnd;
    logic             r_zero;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count;
    logic [16:0]      r_heap_end;
    logic [16:0]      r_limit;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [16:0]      r_hit_cap;
    logic             r_fit;
    logic [IDX_W-1:0] r_fit_idx;
    logic [15:0]      r_fit_start;
    logic             r_op_free_k, r_op_used_k, r_op_take, r_op_app;
    logic [IDX_W-1:0] r_app_idx;
    logic [15:0]      r_app_start;
    t_rsp             r_rsp;
    logic             r_out_valid;
    t_rsp             r_out;

    t_chunk w_cell [MAX_CHUNKS];
    t_chunk w_head, w_tail;
    logic   w_shift;

    assign w_head  = w_cell[0];
    assign w_shift = (r_state == S_SCAN) || (r_state == S_UPD);

    genvar g;
    generate
        for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
            if (g == MAX_CHUNKS - 1) begin : g_last
                ffha_cell u_cell (
                    .i_clk(i_clk), .i_shift(w_shift), .i_chunk(w_tail), .o_chunk(w_cell[g])
                );
            end else begin : g_mid
                ffha_cell u_cell (
                    .i_clk(i_clk), .i_shift(w_shift), .i_chunk(w_cell[g+1]),
                    .o_chunk(w_cell[g])
                );
            end
        end
    endgenerate

    // entry leaving the head, with updates applied in the update pass
    always_comb begin
        w_tail = w_head;
        if (r_state == S_UPD) begin
            if (r_op_free_k && r_idx == r_hit_idx) begin
                w_tail.free = 1'b1;
            end
            if (r_op_used_k && r_idx == r_hit_idx) begin
                w_tail.used = r_req.req_size[16:0];
            end
            if (r_op_take && r_idx == r_fit_idx) begin
                w_tail.free = 1'b0;
                w_tail.used = r_sz[16:0];
            end
            if (r_op_app && r_idx == r_app_idx) begin
                w_tail.start = r_app_start;
                w_tail.cap   = r_rnd[16:0];
                w_tail.used  = r_sz[16:0];
                w_tail.free  = 1'b0;
            end
        end
    end

    logic [63:0] w_total;
    logic        w_big;
    logic [17:0] w_sz;
    logic        w_live;
    logic [18:0] w_need;
    logic [16:0] w_lim;

    assign w_total = (r_req.cmd == CMD_CALLOC) ? r_prod : {32'd0, r_req.req_size};
    assign w_big   = |w_total[63:17];
    assign w_sz    = w_big ? 18'h20000 : {1'b0, w_total[16:0]};
    assign w_live  = {1'b0, r_idx} < r_count;
    assign w_need  = {2'b00, r_heap_end} + 19'(HEADER_BYTES) + {1'b0, r_rnd};
    assign w_lim   = (r_limit > HEAP_CAP) ? HEAP_CAP : r_limit;

    // decision
    logic n_free_k, n_used_k, n_take, n_app;
    t_rsp n_rsp;
    logic w_do_alloc, w_zero_fail, w_nomem;

    always_comb begin
        n_free_k    = 1'b0;
        n_used_k    = 1'b0;
        n_take      = 1'b0;
        n_app       = 1'b0;
        n_rsp       = '0;
        w_do_alloc  = 1'b0;
        w_zero_fail = 1'b0;
        w_nomem     = (r_count >= CNT_W'(MAX_CHUNKS)) || (w_need > {2'b00, w_lim});
        unique case (r_req.cmd)
            CMD_ALLOC, CMD_CALLOC: begin
                if (r_zero) w_zero_fail = 1'b1;
                else        w_do_alloc  = 1'b1;
            end
            CMD_FREE: begin
                if (r_req.data_addr == 16'd0) begin
                    n_rsp.status = ST_OK;
                end else if (!r_hit) begin
                    n_rsp.status = ST_UNKNOWN;
                end else begin
                    n_free_k     = 1'b1;
                    n_rsp.status = ST_FREED;
                end
            end
            default: begin
                if (r_req.data_addr == 16'd0) begin
                    if (r_zero) w_zero_fail = 1'b1;
                    else        w_do_alloc  = 1'b1;
                end else if (!r_hit) begin
                    n_rsp.status = ST_UNKNOWN;
                end else if (r_zero) begin
                    n_free_k     = 1'b1;
                    n_rsp.status = ST_FREED;
                end else if ({1'b0, r_hit_cap} >= r_sz) begin
                    n_used_k          = 1'b1;
                    n_rsp.status      = ST_OK;
                    n_rsp.result_addr = r_req.data_addr;
                    n_rsp.reused      = 1'b1;
                end else begin
                    w_do_alloc = 1'b1;
                end
            end
        endcase
        if (w_zero_fail) begin
            n_rsp.status = ST_ZERO;
        end
        if (w_do_alloc) begin
            if (r_fit) begin
                n_take            = 1'b1;
                n_rsp.status      = ST_OK;
                n_rsp.result_addr = r_fit_start;
                n_rsp.reused      = 1'b1;
            end else if (w_nomem) begin
                n_rsp.status = ST_NOMEM;
            end else begin
                n_app             = 1'b1;
                n_rsp.status      = ST_OK;
                n_rsp.result_addr = r_heap_end[15:0] + 16'(HEADER_BYTES);
            end
            if (n_take || n_app) begin
                if (r_req.cmd == CMD_CALLOC) begin
                    n_rsp.zero_fill = 1'b1;
                end
                if (r_req.cmd == CMD_REALLOC && r_req.data_addr != 16'd0) begin
                    n_free_k         = 1'b1;
                    n_rsp.copy_from  = r_req.data_addr;
                    n_rsp.copy_bytes = r_hit_cap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_heap_end  <= 17'(HEADER_BYTES);
            r_limit     <= 17'h10000;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_beat;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= {32'd0, r_req.req_size} * {32'd0, r_req.elem_count};
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_sz    <= w_sz;
                    r_rnd   <= (w_sz + 18'(ALIGN_BYTES - 1)) & ~18'(ALIGN_BYTES - 1);
                    r_zero  <= (w_total == 64'd0);
                    r_hit   <= 1'b0;
                    r_fit   <= 1'b0;
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_live && !w_head.free && w_head.start == r_req.data_addr && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_idx;
                        r_hit_cap <= w_head.cap;
                    end
                    if (w_live && w_head.free && {1'b0, w_head.cap} >= r_rnd && !r_fit) begin
                        r_fit       <= 1'b1;
                        r_fit_idx   <= r_idx;
                        r_fit_start <= w_head.start;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_W'(MAX_CHUNKS - 1)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_op_free_k <= n_free_k;
                    r_op_used_k <= n_used_k;
                    r_op_take   <= n_take;
                    r_op_app    <= n_app;
                    r_app_idx   <= r_count[IDX_W-1:0];
                    r_app_start <= r_heap_end[15:0] + 16'(HEADER_BYTES);
                    r_rsp       <= n_rsp;
                    if (n_app) begin
                        r_count    <= r_count + 1'b1;
                        r_heap_end <= w_need[16:0];
                    end
                    r_idx   <= '0;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_W'(MAX_CHUNKS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_rsp;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`include "first_fit_heap_allocator_core_macros.svh"

    `FFHA_ASSERT_IMPL(a_count_max, 1'b1, r_count <= CNT_W'(MAX_CHUNKS))
    `FFHA_ASSERT_IMPL(a_heap_end_range, 1'b1, r_heap_end >= 17'(HEADER_BYTES) && r_heap_end <= HEAP_CAP)
    `FFHA_ASSERT_IMPL(a_zero_fill_ok, o_out_valid && o_out_beat.zero_fill, o_out_beat.status == ST_OK && o_out_beat.result_addr != 16'd0)
    `FFHA_ASSERT_NEXT(a_count_step, r_state != S_DECIDE, r_count == $past(r_count))

endmodule
